### hdl/sv39ptm_pkg.sv
// ----------------------------------------------------------------------------
// sv39ptm_pkg
// Shared constants and controller/datapath interface types for the Sv39
// page table mapper.
// ----------------------------------------------------------------------------
package sv39ptm_pkg;

    localparam int VA_W    = 27;
    localparam int PPN_W   = 44;
    localparam int PERM_W  = 8;
    localparam int IDX_W   = 9;
    localparam int ENTRY_W = 64;
    localparam int LEVEL_W = 2;
    localparam int STAT_W  = 2;
    localparam int SLOT_OUT_W = 6;

    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    localparam logic [PPN_W-1:0] POOL_BASE_RST = 44'd524288;

    localparam logic [LEVEL_W-1:0] LEVEL_ROOT = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_MID  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd0;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic load;
        logic rd;
        logic clr_page_init;
        logic clr_wr;
        logic descend_hit;
        logic wr_ptr;
        logic wr_leaf;
        logic err_full;
        logic err_range;
    } t_dp_cmd;

    typedef struct packed {
        logic entry_v;
        logic off_bad;
        logic pool_full;
        logic at_root;
        logic row_end;
        logic slot_end;
    } t_dp_stat;

endpackage

### hdl/sv39_page_table_mapper.sv
// ----------------------------------------------------------------------------
// sv39_page_table_mapper
// Inserts one 4 KiB Sv39 mapping per transaction into a three-level page
// table held in an internal pool of table pages.
// ----------------------------------------------------------------------------
// After reset busy stays high while the table store is zeroed one entry per
// cycle; configuration writes are taken then. A transaction with both
// directory entries present keeps busy high through a table read and check
// at each directory level and then the leaf write. Each allocated table
// adds the zeroing of its page and one pointer write. Each result appears
// in the cycle after its entry write or error; the receiver cannot stall.
module sv39_page_table_mapper #(
    parameter int TABLE_PAGES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [sv39ptm_pkg::PPN_W-1:0]        i_cfg_wr_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [sv39ptm_pkg::VA_W-1:0]         i_va_page,
    input  logic [sv39ptm_pkg::PPN_W-1:0]        i_pa_page,
    input  logic [sv39ptm_pkg::PERM_W-1:0]       i_perm,
    input  logic                                 i_last_in_range,
    output logic                                 o_strobe,
    output logic [sv39ptm_pkg::LEVEL_W-1:0]      o_level,
    output logic [sv39ptm_pkg::SLOT_OUT_W-1:0]   o_table_slot,
    output logic [sv39ptm_pkg::IDX_W-1:0]        o_entry_index,
    output logic [sv39ptm_pkg::ENTRY_W-1:0]      o_entry_value,
    output logic [sv39ptm_pkg::STAT_W-1:0]       o_status,
    output logic                                 o_is_last,
    output logic                                 o_range_done
);
    import sv39ptm_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sv39ptm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    sv39ptm_datapath #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_va_page       (i_va_page),
        .i_pa_page       (i_pa_page),
        .i_perm          (i_perm),
        .i_last_in_range (i_last_in_range),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_strobe        (o_strobe),
        .o_level         (o_level),
        .o_table_slot    (o_table_slot),
        .o_entry_index   (o_entry_index),
        .o_entry_value   (o_entry_value),
        .o_status        (o_status),
        .o_is_last       (o_is_last),
        .o_range_done    (o_range_done)
    );

endmodule

### hdl/sv39ptm_ctrl.sv
// ----------------------------------------------------------------------------
// sv39ptm_ctrl
// Walk sequencer: store clear after reset, two directory lookups, table
// allocation with page zeroing, the leaf write, and full/range error exits.
// ----------------------------------------------------------------------------
module sv39ptm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    output sv39ptm_pkg::t_dp_cmd o_cmd,
    input  sv39ptm_pkg::t_dp_stat i_stat
);
    import sv39ptm_pkg::*;

    localparam logic [2:0] S_CLR_ALL  = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_LOOKUP   = 3'd2;
    localparam logic [2:0] S_CHECK    = 3'd3;
    localparam logic [2:0] S_CLR_PAGE = 3'd4;
    localparam logic [2:0] S_PTR      = 3'd5;
    localparam logic [2:0] S_LEAF     = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_ALL;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR_ALL: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.row_end && i_stat.slot_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                priority if (i_stat.entry_v && i_stat.off_bad) begin
                    o_cmd.err_range = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_stat.entry_v) begin
                    o_cmd.descend_hit = 1'b1;
                    n_state           = i_stat.at_root ? S_LOOKUP : S_LEAF;
                end else if (i_stat.pool_full) begin
                    o_cmd.err_full = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.clr_page_init = 1'b1;
                    n_state             = S_CLR_PAGE;
                end
            end
            S_CLR_PAGE: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.row_end) begin
                    n_state = S_PTR;
                end
            end
            S_PTR: begin
                o_cmd.wr_ptr = 1'b1;
                n_state      = i_stat.at_root ? S_LOOKUP : S_LEAF;
            end
            S_LEAF: begin
                o_cmd.wr_leaf = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_LOOKUP))
        else $error("accepted transaction did not start a lookup");

    a_ptr_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PTR) |-> ($past(r_state) == S_CLR_PAGE))
        else $error("pointer write without page clear");

    a_leaf_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEAF) |-> ($past(r_state) == S_CHECK || $past(r_state) == S_PTR))
        else $error("leaf write without resolved middle table");
`endif

endmodule

### hdl/sv39ptm_datapath.sv
// ----------------------------------------------------------------------------
// sv39ptm_datapath
// Table store, walk registers, free slot counter, entry formatting and the
// registered result port.
// ----------------------------------------------------------------------------
module sv39ptm_datapath #(
    parameter int TABLE_PAGES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [sv39ptm_pkg::PPN_W-1:0]        i_cfg_wr_data,
    input  logic [sv39ptm_pkg::VA_W-1:0]         i_va_page,
    input  logic [sv39ptm_pkg::PPN_W-1:0]        i_pa_page,
    input  logic [sv39ptm_pkg::PERM_W-1:0]       i_perm,
    input  logic                                 i_last_in_range,
    input  sv39ptm_pkg::t_dp_cmd                 i_cmd,
    output sv39ptm_pkg::t_dp_stat                o_stat,
    output logic                                 o_strobe,
    output logic [sv39ptm_pkg::LEVEL_W-1:0]      o_level,
    output logic [sv39ptm_pkg::SLOT_OUT_W-1:0]   o_table_slot,
    output logic [sv39ptm_pkg::IDX_W-1:0]        o_entry_index,
    output logic [sv39ptm_pkg::ENTRY_W-1:0]      o_entry_value,
    output logic [sv39ptm_pkg::STAT_W-1:0]       o_status,
    output logic                                 o_is_last,
    output logic                                 o_range_done
);
    import sv39ptm_pkg::*;

    localparam int SLOT_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int CNT_W  = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W = SLOT_W + IDX_W;
    localparam int DEPTH  = TABLE_PAGES * (1 << IDX_W);
    localparam logic [PPN_W-1:0]  POOL_SIZE = PPN_W'(TABLE_PAGES);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_PAGES - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(TABLE_PAGES);

    logic [ENTRY_W-1:0] r_mem [DEPTH];

    logic [VA_W-1:0]    r_va;
    logic [PPN_W-1:0]   r_pa;
    logic [PERM_W-1:0]  r_perm;
    logic               r_last;
    logic [PPN_W-1:0]   r_base;
    logic [LEVEL_W-1:0] r_level;
    logic [SLOT_W-1:0]  r_slot;
    logic [IDX_W-1:0]   r_index;
    logic [CNT_W-1:0]   r_next_free;
    logic [SLOT_W-1:0]  r_clr_slot;
    logic [IDX_W-1:0]   r_clr_idx;
    logic [ENTRY_W-1:0] r_rdata;

    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_level;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [IDX_W-1:0]   r_out_index;
    logic [ENTRY_W-1:0] r_out_value;
    logic [STAT_W-1:0]  r_out_status;
    logic               r_out_last;
    logic               r_out_range;

    logic [PPN_W-1:0]   w_off;
    logic [PPN_W-1:0]   w_alloc_ppn;
    logic [ENTRY_W-1:0] w_ptr_val;
    logic [ENTRY_W-1:0] w_leaf_val;
    logic [SLOT_W-1:0]  n_child;
    logic [IDX_W-1:0]   n_index;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [ADDR_W-1:0]  w_raddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic               w_emit;
    logic               w_descend;

    assign w_off       = r_rdata[PPN_W+9:10] - r_base;
    assign w_alloc_ppn = r_base + PPN_W'(r_next_free);
    assign w_ptr_val   = {10'd0, w_alloc_ppn, 9'd0, 1'b1};
    assign w_leaf_val  = {10'd0, r_pa, 2'd0, r_perm};
    assign n_child     = i_cmd.wr_ptr ? r_next_free[SLOT_W-1:0] : w_off[SLOT_W-1:0];
    assign n_index     = (r_level == LEVEL_ROOT) ? r_va[2*IDX_W-1:IDX_W] : r_va[IDX_W-1:0];
    assign w_descend   = i_cmd.descend_hit || i_cmd.wr_ptr;

    assign w_we    = i_cmd.clr_wr || i_cmd.wr_ptr || i_cmd.wr_leaf;
    assign w_raddr = {r_slot, r_index};
    assign w_waddr = i_cmd.clr_wr ? {r_clr_slot, r_clr_idx} : {r_slot, r_index};
    assign w_wdata = i_cmd.clr_wr ? '0 : (i_cmd.wr_ptr ? w_ptr_val : w_leaf_val);
    assign w_emit  = i_cmd.wr_ptr || i_cmd.wr_leaf || i_cmd.err_full || i_cmd.err_range;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= POOL_BASE_RST;
        end else if (i_cfg_wr_en) begin
            r_base <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_va   <= i_va_page;
            r_pa   <= i_pa_page;
            r_perm <= i_perm;
            r_last <= i_last_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LEVEL_ROOT;
            r_slot      <= '0;
            r_index     <= '0;
            r_next_free <= CNT_W'(1);
            r_clr_slot  <= '0;
            r_clr_idx   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_level <= LEVEL_ROOT;
                r_slot  <= '0;
                r_index <= i_va_page[3*IDX_W-1:2*IDX_W];
            end else if (w_descend) begin
                r_level <= LEVEL_W'(r_level - 2'd1);
                r_slot  <= n_child;
                r_index <= n_index;
            end
            if (i_cmd.wr_ptr) begin
                r_next_free <= CNT_W'(r_next_free + 1'b1);
            end
            if (i_cmd.clr_page_init) begin
                r_clr_slot <= r_next_free[SLOT_W-1:0];
                r_clr_idx  <= '0;
            end else if (i_cmd.clr_wr) begin
                r_clr_idx <= IDX_W'(r_clr_idx + 1'b1);
                if (r_clr_idx == IDX_MAX) begin
                    r_clr_slot <= SLOT_W'(r_clr_slot + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_level  <= r_level;
            r_out_slot   <= r_slot;
            r_out_index  <= r_index;
            r_out_last   <= !i_cmd.wr_ptr;
            r_out_range  <= !i_cmd.wr_ptr && r_last;
            priority if (i_cmd.err_full) begin
                r_out_value  <= '0;
                r_out_status <= STATUS_FULL;
            end else if (i_cmd.err_range) begin
                r_out_value  <= '0;
                r_out_status <= STATUS_RANGE;
            end else if (i_cmd.wr_ptr) begin
                r_out_value  <= w_ptr_val;
                r_out_status <= STATUS_OK;
            end else begin
                r_out_value  <= w_leaf_val;
                r_out_status <= STATUS_OK;
            end
        end
    end

    assign o_stat.entry_v   = r_rdata[0];
    assign o_stat.off_bad   = (w_off >= POOL_SIZE);
    assign o_stat.pool_full = (r_next_free >= CNT_FULL);
    assign o_stat.at_root   = (r_level == LEVEL_ROOT);
    assign o_stat.row_end   = (r_clr_idx == IDX_MAX);
    assign o_stat.slot_end  = (r_clr_slot == SLOT_LAST);

    assign o_strobe      = r_out_valid;
    assign o_level       = r_out_level;
    assign o_table_slot  = SLOT_OUT_W'(r_out_slot);
    assign o_entry_index = r_out_index;
    assign o_entry_value = r_out_value;
    assign o_status      = r_out_status;
    assign o_is_last     = r_out_last;
    assign o_range_done  = r_out_range;

`ifndef ASSERT_OFF
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= CNT_FULL)
        else $error("free slot counter beyond pool");

    a_slot_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("walk slot outside pool");

    a_final_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |=> !r_out_valid)
        else $error("result after final result of a transaction");

    a_ptr_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_ptr |=> (r_next_free == CNT_W'($past(r_next_free) + 1'b1)))
        else $error("allocation did not advance free slot counter");
`endif

endmodule
